/* design/stfir_pkg.sv */
// Package for the stereo FIR block: sizes, transaction payload types and lane control.
// Depends on nothing. Every other file in the design imports it.
package stfir_pkg;

	localparam int TAPS       = 21;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int INDEX_W    = 5;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int PROD_SHIFT = 15;
	localparam int CNT_W      = (TAPS > SAMPLE_W) ? $clog2(TAPS) : $clog2(SAMPLE_W);

	typedef enum logic [0:0] {
		MODE_SAMPLE = 1'b0,
		MODE_COEF   = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                       mode;
		logic signed [SAMPLE_W-1:0]  sample_value;
		logic        [INDEX_W-1:0]   coef_index;
		logic signed [COEF_W-1:0]    coef_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_sample;
		logic                       is_left;
	} out_item_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic neg;
		logic shift;
	} lane_ctrl_t;

endpackage

/* design/stfir_mac_lane.sv */
// One filter tap: a bit-serial signed multiplier that takes one sample bit per cycle while step is set.
// The truncated product then moves down the lane chain to the accumulator. Uses stfir_pkg.
module stfir_mac_lane (
	input  logic                                clk,
	input  stfir_pkg::lane_ctrl_t               ctrl,
	input  logic                                sample_bit,
	input  logic signed [stfir_pkg::COEF_W-1:0] coef,
	input  logic        [stfir_pkg::SAMPLE_W-1:0] slice_in,
	output logic        [stfir_pkg::SAMPLE_W-1:0] slice_out
);
	import stfir_pkg::*;

	logic signed [PROD_W-1:0]  prod_q;
	logic signed [COEF_W:0]    hi_ext;
	logic signed [COEF_W:0]    coef_ext;
	logic signed [COEF_W:0]    addend;
	logic signed [COEF_W:0]    sum;

	always_comb begin
		hi_ext   = {prod_q[PROD_W-1], prod_q[PROD_W-1 -: COEF_W]};
		coef_ext = {coef[COEF_W-1], coef};
		if (!sample_bit) begin
			addend = '0;
		end else if (ctrl.neg) begin
			addend = -coef_ext;
		end else begin
			addend = coef_ext;
		end
		sum = hi_ext + addend;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			prod_q <= '0;
		end else if (ctrl.step) begin
			prod_q <= {sum, prod_q[SAMPLE_W-1:1]};
		end else if (ctrl.shift) begin
			prod_q <= {1'b0, slice_in, {PROD_SHIFT{1'b0}}};
		end
	end

	assign slice_out = prod_q[PROD_SHIFT + SAMPLE_W - 1 : PROD_SHIFT];

endmodule

/* design/stereo_fir_left_channel.sv */
// Top level of the stereo FIR block: delay line, coefficient table and control sequencer.
// Depends on stfir_pkg and stfir_mac_lane.
//
// Items arrive on the item channel and results leave on the result channel, both valid/ready.
// A coefficient transaction writes the indexed entry, if in range, in its accept cycle and gives no result.
// Audio samples alternate left and right, starting with left after reset.
// A right sample is passed through; it is held in the result register until the output register is free.
// A left sample is multiplied bit-serially, one sample bit per cycle in all taps at once, then
// the truncated products of the taps are added one after another in a single accumulator.
// The next item is taken once the result has moved to the output register, so one result
// may wait there while the next item is at work.
// When the receiver stalls, the finished result waits in the sequencer until the output
// register is free, and no new item is accepted meanwhile.
// Reset clears the delay line, the coefficient table and the channel phase.
module stereo_fir_left_channel (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  stfir_pkg::in_item_t  item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output stfir_pkg::out_item_t result
);
	import stfir_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ACC  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        phase_q;
	logic                        out_valid_q;
	out_item_t                   out_q;
	out_item_t                   res_q;
	logic [SAMPLE_W-1:0]         acc_q;
	logic signed [SAMPLE_W-1:0]  delay_q [TAPS];
	logic signed [COEF_W-1:0]    coef_q  [TAPS];
	logic [SAMPLE_W-1:0]         slice   [TAPS+1];
	lane_ctrl_t                  lane_ctrl;
	logic                        accept;
	logic                        accept_left;
	logic                        accept_right;
	logic                        out_free;
	logic                        mul_last;
	logic                        acc_last;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign accept_left  = accept && (item.mode == MODE_SAMPLE) && !phase_q;
	assign accept_right = accept && (item.mode == MODE_SAMPLE) && phase_q;
	assign out_free     = !out_valid_q || result_ready;
	assign mul_last     = (cnt_q == CNT_W'(SAMPLE_W - 1));
	assign acc_last     = (cnt_q == CNT_W'(TAPS - 1));

	assign lane_ctrl.clear = accept_left;
	assign lane_ctrl.step  = (state_q == ST_MUL);
	assign lane_ctrl.neg   = mul_last;
	assign lane_ctrl.shift = (state_q == ST_ACC);

	assign slice[TAPS] = '0;

	for (genvar k = 0; k < TAPS; k++) begin : g_lane
		stfir_mac_lane u_lane (
			.clk        (clk),
			.ctrl       (lane_ctrl),
			.sample_bit (delay_q[k][0]),
			.coef       (coef_q[k]),
			.slice_in   (slice[k+1]),
			.slice_out  (slice[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept_left) begin
						state_q <= ST_MUL;
					end else if (accept_right) begin
						state_q <= ST_FIN;
					end
					if (accept_left || accept_right) begin
						phase_q <= ~phase_q;
					end
				end
				ST_MUL: begin
					if (mul_last) begin
						cnt_q   <= '0;
						state_q <= ST_ACC;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ACC: begin
					if (acc_last) begin
						cnt_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				delay_q[k] <= '0;
				coef_q[k]  <= '0;
			end
		end else begin
			if (accept && (item.mode == MODE_COEF)) begin
				for (int k = 0; k < TAPS; k++) begin
					if (int'(item.coef_index) == k) begin
						coef_q[k] <= item.coef_value;
					end
				end
			end
			if (accept_left) begin
				delay_q[0] <= item.sample_value;
			end else if (state_q == ST_MUL) begin
				for (int k = 0; k < TAPS; k++) begin
					delay_q[k] <= {delay_q[k][0], delay_q[k][SAMPLE_W-1:1]};
				end
			end else if ((state_q == ST_ACC) && acc_last) begin
				for (int k = 1; k < TAPS; k++) begin
					delay_q[k] <= delay_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			acc_q <= '0;
		end else if (state_q == ST_ACC) begin
			acc_q <= acc_q + slice[0];
		end
		if (accept_right) begin
			res_q.out_sample <= item.sample_value;
			res_q.is_left    <= 1'b0;
		end else if ((state_q == ST_ACC) && acc_last) begin
			res_q.out_sample <= acc_q + slice[0];
			res_q.is_left    <= 1'b1;
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_left_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept_left |=> (state_q == ST_MUL) && (cnt_q == '0))
		else $error("Left sample did not start the multiply phase.");

	a_mul_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) && mul_last |=> (state_q == ST_ACC) && (cnt_q == '0))
		else $error("Multiply phase did not hand over to accumulation.");

	a_right_passes: assert property (@(posedge clk) disable iff (!arst_n)
		accept_right |=> (state_q == ST_FIN) && !res_q.is_left
		&& (res_q.out_sample == $past(item.sample_value)))
		else $error("Right sample was not passed through.");

	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (int'(cnt_q) < TAPS))
		else $error("Accumulation counter ran past the last tap.");

endmodule

/* test/testbench.sv */
// Self-checking testbench for stereo_fir_left_channel: interleaved audio and coefficient
// transactions, with a built-in predictor of the left-channel FIR and right pass-through.
// Depends on stfir_pkg and the stereo_fir_left_channel RTL.
module testbench;
	import stfir_pkg::*;

	localparam int IDLE_MAX   = 17;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 60;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	logic signed [SAMPLE_W-1:0] tap_history [TAPS];
	logic signed [COEF_W-1:0]   tap_coef [TAPS];
	logic                       next_is_right;

	out_item_t awaited_outputs [$];
	bit        src_idle;
	bit        sink_idle;
	int        errors;
	int        quiet_cycles;
	int        n_left;
	int        n_right;
	int        n_coef;
	int        n_coef_skipped;
	int        n_checked;

	stereo_fir_left_channel i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void filter_predict(input in_item_t it, output logic produces,
			output out_item_t res);
		int               prod;
		logic [SAMPLE_W-1:0] acc;
		produces = 1'b0;
		res = '0;
		if (it.mode == MODE_COEF) begin
			if (it.coef_index < TAPS)
				tap_coef[it.coef_index] = it.coef_value;
		end else if (!next_is_right) begin
			tap_history[0] = it.sample_value;
			acc = '0;
			for (int k = 0; k < TAPS; k++) begin
				prod = int'(tap_coef[k]) * int'(tap_history[k]);
				acc = acc + SAMPLE_W'(prod >>> PROD_SHIFT);
			end
			for (int k = TAPS - 1; k >= 1; k--)
				tap_history[k] = tap_history[k - 1];
			res.out_sample = acc;
			res.is_left = 1'b1;
			produces = 1'b1;
			next_is_right = 1'b1;
		end else begin
			res.out_sample = it.sample_value;
			res.is_left = 1'b0;
			produces = 1'b1;
			next_is_right = 1'b0;
		end
	endfunction

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			3: return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t audio_item(input logic signed [SAMPLE_W-1:0] v);
		in_item_t it;
		it.mode = MODE_SAMPLE;
		it.sample_value = v;
		it.coef_index = INDEX_W'($urandom);
		it.coef_value = COEF_W'($urandom);
		return it;
	endfunction

	function automatic in_item_t coef_item(input logic [INDEX_W-1:0] idx,
			input logic signed [COEF_W-1:0] v);
		in_item_t it;
		it.mode = MODE_COEF;
		it.sample_value = SAMPLE_W'($urandom);
		it.coef_index = idx;
		it.coef_value = v;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int        gap;
		logic      produces;
		out_item_t res;
		gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		filter_predict(it, produces, res);
		if (produces) begin
			awaited_outputs.push_back(res);
			if (res.is_left)
				n_left++;
			else
				n_right++;
		end else begin
			n_coef++;
			if (it.coef_index >= TAPS)
				n_coef_skipped++;
		end
	endtask

	always begin
		int        stall;
		out_item_t want;
		wait (arst_n);
		stall = sink_idle ? $urandom_range(0, IDLE_MAX) : 0;
		@(negedge clk);
		if (stall != 0) begin
			result_ready <= 1'b0;
			repeat (stall) @(negedge clk);
		end
		result_ready <= 1'b1;
		do @(posedge clk); while (!result_valid);
		n_checked++;
		if (awaited_outputs.size() == 0) begin
			$error("unexpected result transaction: out_sample %0d is_left %0b",
				result.out_sample, result.is_left);
			errors++;
		end else begin
			want = awaited_outputs.pop_front();
			if (result.out_sample !== want.out_sample) begin
				$error("out_sample: expected %0d, got %0d", want.out_sample, result.out_sample);
				errors++;
			end
			if (result.is_left !== want.is_left) begin
				$error("is_left: expected %0b, got %0b", want.is_left, result.is_left);
				errors++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
					STALL_LIMIT, awaited_outputs.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// With an all-zero table the left result is zero and the right sample comes back as is.
	task automatic test_after_reset();
		src_idle = 1'b1;
		sink_idle = 1'b1;
		send_item(audio_item(16'sh7FFF));
		send_item(audio_item(16'sh8000));
	endtask

	// The most negative coefficient times the most negative sample gives 32768, which wraps.
	// A coefficient write between left and right must not disturb the channel phase.
	task automatic test_coef_extremes();
		send_item(coef_item(5'd0, 16'sh8000));
		send_item(coef_item(INDEX_W'(TAPS - 1), 16'sh7FFF));
		send_item(audio_item(16'sh8000));
		send_item(coef_item(5'd5, 16'sh0001));
		send_item(audio_item(16'sh7FFF));
		send_item(audio_item(16'sh0000));
		send_item(audio_item(-16'sd1));
	endtask

	task automatic test_index_past_table();
		send_item(coef_item(INDEX_W'(TAPS), 16'sh7FFF));
		send_item(coef_item(5'h1F, -16'sd1));
		send_item(audio_item(16'sh1234));
		send_item(audio_item(-16'sd4660));
	endtask

	// A small negative product must round toward minus infinity, not toward zero.
	task automatic test_negative_floor();
		send_item(coef_item(5'd0, 16'sh0001));
		send_item(audio_item(-16'sd1));
		send_item(audio_item(16'sh4000));
	endtask

	task automatic test_random_stream(input int count, input bit src_gaps, input bit sink_gaps);
		src_idle = src_gaps;
		sink_idle = sink_gaps;
		for (int k = 0; k < TAPS; k++)
			send_item(coef_item(INDEX_W'(k), pick_value()));
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 12) begin
				if ($urandom_range(0, 7) == 0)
					send_item(coef_item(INDEX_W'($urandom_range(TAPS, 31)), pick_value()));
				else
					send_item(coef_item(INDEX_W'($urandom_range(0, TAPS - 1)), pick_value()));
			end else begin
				send_item(audio_item(pick_value()));
			end
		end
	endtask

	initial begin
		for (int k = 0; k < TAPS; k++) begin
			tap_history[k] = '0;
			tap_coef[k] = '0;
		end
		next_is_right = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_coef_extremes();
		test_index_past_table();
		test_negative_floor();
		test_random_stream(130, 1'b0, 1'b0);
		test_random_stream(130, 1'b0, 1'b1);
		test_random_stream(130, 1'b1, 1'b0);
		test_random_stream(270, 1'b1, 1'b1);

		@(negedge clk);
		item_valid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d left, %0d right and %0d coefficient transactions (%0d past the table).",
			n_left, n_right, n_coef, n_coef_skipped);
		$display("Compared %0d result transactions against the predicted filter output.", n_checked);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
design/stfir_pkg.sv
design/stfir_mac_lane.sv
design/stereo_fir_left_channel.sv
test/testbench.sv
